// ===== hdl/spd_pkg.sv =====
// Shared types, codes and constants for the sensor packet deframer.
`timescale 1ns / 1ps

package spd_pkg;

  // Field widths
  localparam int unsigned POS_W   = 10;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;

  // Default receive buffer size in bytes (header plus payload area)
  localparam int unsigned BUFFER_BYTES_DEF = 64;

  // Register reset values
  localparam logic [CODE_W-1:0] SYNC_WORD_RST = 16'hEF01;
  localparam logic [TICK_W-1:0] TIMEOUT_RST   = 16'd1000;

  // Byte positions within the packet header
  localparam logic [POS_W-1:0] POS_HUNT       = 10'd0;
  localparam logic [POS_W-1:0] POS_START_LO   = 10'd1;
  localparam logic [POS_W-1:0] POS_ADDR_FIRST = 10'd2;
  localparam logic [POS_W-1:0] POS_ADDR_LAST  = 10'd5;
  localparam logic [POS_W-1:0] POS_TYPE       = 10'd6;
  localparam logic [POS_W-1:0] POS_LEN_HI     = 10'd7;
  localparam logic [POS_W-1:0] POS_LEN_LO     = 10'd8;
  // Payload starts here; length counts from one position earlier
  localparam logic [POS_W-1:0] POS_PAYLOAD    = 10'd9;
  localparam logic [LEN_W-1:0] LEN_OFFSET     = 16'd8;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } spd_cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_TIMEOUT = 2'd2
  } spd_status_e;

  typedef enum logic {
    REG_SYNC_WORD = 1'b0,
    REG_TIMEOUT   = 1'b1
  } spd_reg_e;

  typedef struct packed {
    logic [CODE_W-1:0] sync_word;
    logic [TICK_W-1:0] timeout_ms;
  } spd_cfg_t;

  typedef struct packed {
    logic              has_data;
    logic [BYTE_W-1:0] data_byte;
    logic [IDX_W-1:0]  data_index;
    logic              done_res;
    spd_status_e       status;
    logic [BYTE_W-1:0] packet_type;
    logic [LEN_W-1:0]  packet_length;
    logic [ADDR_W-1:0] source_address;
  } spd_result_t;

endpackage

// ===== hdl/spd_cfg.sv =====
// APB register file holding the start code and the timeout limit.
`timescale 1ns / 1ps

module spd_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spd_pkg::APB_AW-1:0] paddr,
  input  logic [spd_pkg::APB_DW-1:0] pwdata,
  output logic [spd_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output spd_pkg::spd_cfg_t          cfg_o
);
  import spd_pkg::*;

  logic [CODE_W-1:0] sync_word_q, sync_word_d;
  logic [TICK_W-1:0] timeout_q, timeout_d;
  spd_reg_e          reg_sel;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_sel = spd_reg_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite & pready;

  // Write decode
  always_comb begin
    sync_word_d = sync_word_q;
    timeout_d   = timeout_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_SYNC_WORD: sync_word_d = pwdata[CODE_W-1:0];
        REG_TIMEOUT:   timeout_d   = pwdata[TICK_W-1:0];
        default:       ;
      endcase
    end
  end

  // Read decode
  always_comb begin
    unique case (reg_sel)
      REG_SYNC_WORD: prdata = {{(APB_DW-CODE_W){1'b0}}, sync_word_q};
      REG_TIMEOUT:   prdata = {{(APB_DW-TICK_W){1'b0}}, timeout_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q <= SYNC_WORD_RST;
      timeout_q   <= TIMEOUT_RST;
    end else begin
      sync_word_q <= sync_word_d;
      timeout_q   <= timeout_d;
    end
  end

  assign cfg_o.sync_word  = sync_word_q;
  assign cfg_o.timeout_ms = timeout_q;

endmodule

// ===== hdl/spd_core.sv =====
// Packet parse state and per-transaction next-state and result logic.
`timescale 1ns / 1ps

module spd_core #(
  parameter int unsigned BUFFER_BYTES = spd_pkg::BUFFER_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       command_i,
  input  logic [spd_pkg::BYTE_W-1:0] rx_byte_i,
  input  spd_pkg::spd_cfg_t          cfg_i,
  output logic                       res_valid_o,
  output spd_pkg::spd_result_t       res_o
);
  import spd_pkg::*;

  localparam int unsigned BOUND_W = POS_W + 1;
  localparam logic [BOUND_W-1:0] BOUND = BOUND_W'(BUFFER_BYTES);

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [ADDR_W-1:0] address_q, address_d;
  logic [BYTE_W-1:0] type_q, type_d;
  logic [LEN_W-1:0]  length_q, length_d;
  logic [TICK_W-1:0] ticks_q, ticks_d;

  logic [TICK_W-1:0] ticks_inc;
  logic [POS_W-1:0]  pos_inc;
  logic              past_bound;
  logic              advance;
  logic              payload;
  logic [1:0]        lane;
  logic [LEN_W-1:0]  payload_count;

  assign ticks_inc     = (ticks_q != '1) ? ticks_q + 1'b1 : ticks_q;
  assign pos_inc       = pos_q + 1'b1;
  assign past_bound    = ({1'b0, pos_inc} + BOUND_W'(POS_PAYLOAD)) > BOUND;
  // Address bytes arrive most significant first
  assign lane          = 2'(POS_ADDR_LAST - pos_q);
  assign payload_count = LEN_W'(pos_q) - LEN_OFFSET;

  always_comb begin
    pos_d     = pos_q;
    address_d = address_q;
    type_d    = type_q;
    length_d  = length_q;
    ticks_d   = ticks_q;
    advance   = 1'b0;
    payload   = 1'b0;

    res_valid_o      = 1'b0;
    res_o.has_data   = 1'b0;
    res_o.data_byte  = '0;
    res_o.data_index = '0;
    res_o.done_res   = 1'b0;
    res_o.status     = ST_OK;

    if (spd_cmd_e'(command_i) == CMD_TICK) begin
      // Millisecond tick: saturating timer, timeout ends the attempt
      ticks_d = ticks_inc;
      if (ticks_inc > cfg_i.timeout_ms) begin
        res_valid_o    = 1'b1;
        res_o.done_res = 1'b1;
        res_o.status   = ST_TIMEOUT;
        pos_d          = POS_HUNT;
        ticks_d        = '0;
      end
    end else begin
      case (pos_q) inside
        POS_HUNT: begin
          if (rx_byte_i == cfg_i.sync_word[CODE_W-1:BYTE_W]) begin
            address_d = '0;
            advance   = 1'b1;
          end
        end
        POS_START_LO: begin
          if (rx_byte_i != cfg_i.sync_word[BYTE_W-1:0]) begin
            res_valid_o    = 1'b1;
            res_o.done_res = 1'b1;
            res_o.status   = ST_BAD;
            pos_d          = POS_HUNT;
            ticks_d        = '0;
          end else begin
            advance = 1'b1;
          end
        end
        [POS_ADDR_FIRST:POS_ADDR_LAST]: begin
          address_d = address_q | ({{(ADDR_W-BYTE_W){1'b0}}, rx_byte_i} << {lane, 3'b000});
          advance   = 1'b1;
        end
        POS_TYPE: begin
          type_d  = rx_byte_i;
          advance = 1'b1;
        end
        POS_LEN_HI: begin
          length_d = {rx_byte_i, {BYTE_W{1'b0}}};
          advance  = 1'b1;
        end
        POS_LEN_LO: begin
          length_d = {length_q[LEN_W-1:BYTE_W], rx_byte_i};
          advance  = 1'b1;
        end
        default: begin
          // Payload or checksum byte
          payload          = 1'b1;
          res_o.has_data   = 1'b1;
          res_o.data_byte  = rx_byte_i;
          res_o.data_index = IDX_W'(pos_q - POS_PAYLOAD);
          if (payload_count == length_q) begin
            res_valid_o    = 1'b1;
            res_o.done_res = 1'b1;
            res_o.status   = ST_OK;
            pos_d          = POS_HUNT;
            ticks_d        = '0;
          end else begin
            advance = 1'b1;
          end
        end
      endcase

      // Position step, then buffer bound check
      if (advance) begin
        pos_d = pos_inc;
        if (past_bound) begin
          res_valid_o    = 1'b1;
          res_o.done_res = 1'b1;
          res_o.status   = ST_BAD;
          pos_d          = POS_HUNT;
          ticks_d        = '0;
        end else if (payload) begin
          res_valid_o = 1'b1;
        end
      end
    end

    if (!in_valid_i) begin
      res_valid_o = 1'b0;
    end

    res_o.packet_type    = type_d;
    res_o.packet_length  = length_d;
    res_o.source_address = address_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= POS_HUNT;
      address_q <= '0;
      type_q    <= '0;
      length_q  <= '0;
      ticks_q   <= '0;
    end else if (in_valid_i) begin
      pos_q     <= pos_d;
      address_q <= address_d;
      type_q    <= type_d;
      length_q  <= length_d;
      ticks_q   <= ticks_d;
    end
  end

endmodule

// ===== hdl/spd_out_buf.sv =====
// Two-entry result register with skid slot for the master-side stream.
`timescale 1ns / 1ps

module spd_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  spd_pkg::spd_result_t push_data_i,
  output logic                 ready_o,
  output logic                 valid_o,
  input  logic                 pop_ready_i,
  output spd_pkg::spd_result_t head_o
);
  import spd_pkg::*;

  logic        v0_q, v0_d, v1_q, v1_d;
  spd_result_t d0_q, d0_d, d1_q, d1_d;
  logic        pop;

  assign pop     = v0_q & pop_ready_i;
  assign ready_o = ~v1_q;
  assign valid_o = v0_q;
  assign head_o  = d0_q;

  // Drain the head, then fill the first free slot
  always_comb begin
    v0_d = v0_q;
    v1_d = v1_q;
    d0_d = d0_q;
    d1_d = d1_q;
    if (pop) begin
      v0_d = v1_q;
      d0_d = d1_q;
      v1_d = 1'b0;
    end
    if (push_i) begin
      if (!v0_d) begin
        v0_d = 1'b1;
        d0_d = push_data_i;
      end else begin
        v1_d = 1'b1;
        d1_d = push_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d0_q <= d0_d;
    d1_q <= d1_d;
  end

endmodule

// ===== hdl/sensor_packet_deframer.sv =====
// Sensor packet deframer: top level with stream ports and APB registers.
//
// Slave stream: one transaction per received serial byte (tuser low, byte in
// tdata) or per millisecond tick (tuser high). Master stream: at most one
// result per input transaction, either a payload/checksum byte with its
// index (tuser high) or an end-of-attempt report (tlast high, status ok, bad
// packet or timeout), carrying the captured type, length and address.
// Throughput is one input transaction per cycle while s_axis_tready is high;
// the parse state updates in the accepting cycle and the result is registered
// in the output buffer before it appears on the master side.
// The output register has a skid slot: input is still taken while one
// result waits, and s_axis_tready drops only when both slots are full.
// Reset returns the parser to start-code hunting, clears the captured header
// fields and tick timer, and loads the default start code and timeout.
// Registers are written over APB (start code at 0x0, timeout at 0x4); the user
// must write them only while the stream is idle: the block does not enforce it.
`timescale 1ns / 1ps

module sensor_packet_deframer #(
  parameter int unsigned BUFFER_BYTES = spd_pkg::BUFFER_BYTES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // APB configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [spd_pkg::APB_AW-1:0] paddr,
  input  logic [spd_pkg::APB_DW-1:0] pwdata,
  output logic [spd_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  // Slave stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // [7:0] rx_byte
  input  logic                       s_axis_tuser,  // [0] command
  // Master stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [7:0] data_byte, [13:8] data_index, [15:14] status, [23:16] packet_type,
  // [39:24] packet_length, [71:40] source_address
  output logic [71:0]                m_axis_tdata,
  output logic                       m_axis_tuser,  // [0] has_data
  output logic                       m_axis_tlast   // done_res
);
  import spd_pkg::*;

  spd_cfg_t    cfg;
  spd_result_t core_res;
  spd_result_t head;
  logic        core_valid;
  logic        buf_ready;
  logic        in_accept;

  assign s_axis_tready = buf_ready;
  assign in_accept     = s_axis_tvalid & s_axis_tready;

  spd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spd_core #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_accept),
    .command_i   (s_axis_tuser),
    .rx_byte_i   (s_axis_tdata),
    .cfg_i       (cfg),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  spd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (core_valid),
    .push_data_i (core_res),
    .ready_o     (buf_ready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .head_o      (head)
  );

  // Pack the result fields onto the master stream
  assign m_axis_tdata = {head.source_address, head.packet_length, head.packet_type,
                         head.status, head.data_index, head.data_byte};
  assign m_axis_tuser = head.has_data;
  assign m_axis_tlast = head.done_res;

  // A result that does not end an attempt always carries a byte
  a_mid_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser)
    else $error("non-final result without payload byte");

  // Status is ok unless the attempt ends here
  a_mid_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> head.status == ST_OK)
    else $error("non-final result with error status");

  // Timeout reports never carry a payload byte
  a_timeout_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && head.status == ST_TIMEOUT |-> !m_axis_tuser && m_axis_tlast)
    else $error("timeout result carries data");

  // Input stalls only when the output holds a result
  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

endmodule
